>>> design/aug_pkg.sv
// Shared types and constants of the angle unwrap and gear ratio core.
// Used by every module of the block; no dependencies.
package aug_pkg;

    localparam int ANGLE_BITS    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int TOTAL_BITS    = 64;
    localparam int PERIOD_BITS   = 31;
    localparam int RATIO_BITS    = 32;
    localparam int DELTA_BITS    = 31;
    localparam int CFG_IDX_BITS  = 2;

    localparam int NUM_BITS      = TOTAL_BITS + FRACTION_BITS;
    localparam int DEN_BITS      = 32;
    localparam int DIV_STEPS     = NUM_BITS / 2;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

    localparam logic [PERIOD_BITS-1:0] FULL_TURN = PERIOD_BITS'(360 << FRACTION_BITS);
    localparam logic [RATIO_BITS-1:0]  ONE_FIX   = RATIO_BITS'(1 << FRACTION_BITS);
    localparam logic [TOTAL_BITS-1:0]  LIM_POS   = {1'b0, {(TOTAL_BITS-1){1'b1}}};
    localparam logic [TOTAL_BITS-1:0]  LIM_NEG   = {1'b1, {(TOTAL_BITS-1){1'b0}}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_INPUT_PERIOD  = 2'd0,
        REG_OUTPUT_PERIOD = 2'd1,
        REG_GEAR_RATIO    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                  neg;
        logic [ANGLE_BITS-1:0] mag;
    } sample_item_t;

    typedef struct packed {
        logic                start;
        logic [NUM_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [NUM_BITS-1:0] quo;
        logic [DEN_BITS-1:0] rem;
    } div_rsp_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MOD_CUR,
        BK_MOD_PREV,
        BK_STEP,
        BK_DIV_GO,
        BK_DIV,
        BK_OUT_GO,
        BK_MOD_OUT,
        BK_FINISH
    } back_state_t;

endpackage

>>> design/angle_unwrap_gear_ratio_core.sv
// Angle unwrap and electronic gearbox, top level with configuration registers.
// Depends on aug_pkg, aug_front, aug_div and aug_back.
//
// Each sample makes four passes through one shared divider that retires two
// quotient bits per cycle (sample wrap, previous-sample wrap, total by gear
// ratio, output wrap). The work side handles one sample at a time; a two-entry
// queue takes new samples and a result register holds a finished result while
// the next sample is being worked on.
// The first sample after reset only sets the baseline and reports valid_res low.
module angle_unwrap_gear_ratio_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [aug_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [aug_pkg::RATIO_BITS-1:0]        cfg_data,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [aug_pkg::ANGLE_BITS-1:0] sample_angle,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic                                  valid_res,
    output logic signed [aug_pkg::DELTA_BITS-1:0] input_delta,
    output logic [aug_pkg::PERIOD_BITS-1:0]       input_wrapped,
    output logic signed [aug_pkg::TOTAL_BITS-1:0] input_total,
    output logic signed [aug_pkg::TOTAL_BITS-1:0] output_total,
    output logic [aug_pkg::PERIOD_BITS-1:0]       output_wrapped,
    output logic signed [aug_pkg::TOTAL_BITS-1:0] output_delta
);
    import aug_pkg::*;

    logic [PERIOD_BITS-1:0] in_period_reg;
    logic [PERIOD_BITS-1:0] out_period_reg;
    logic [RATIO_BITS-1:0]  ratio_reg;
    logic                   q_valid;
    logic                   q_pop;
    sample_item_t           q_item;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_period_reg  <= FULL_TURN;
            out_period_reg <= FULL_TURN;
            ratio_reg      <= ONE_FIX;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_INPUT_PERIOD:  in_period_reg  <= cfg_data[PERIOD_BITS-1:0];
                REG_OUTPUT_PERIOD: out_period_reg <= cfg_data[PERIOD_BITS-1:0];
                REG_GEAR_RATIO:    ratio_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    aug_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_angle (sample_angle),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    aug_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    aug_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_period      (in_period_reg),
        .out_period     (out_period_reg),
        .ratio          (ratio_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .div_req        (div_req),
        .div_rsp        (div_rsp),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .valid_res      (valid_res),
        .input_delta    (input_delta),
        .input_wrapped  (input_wrapped),
        .input_total    (input_total),
        .output_total   (output_total),
        .output_wrapped (output_wrapped),
        .output_delta   (output_delta)
    );

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_baseline_zero_delta: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !valid_res) |-> (input_delta == '0 && output_delta == '0))
        else $error("baseline result carries a nonzero delta");

    a_baseline_total_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !valid_res) |-> !input_total[TOTAL_BITS-1])
        else $error("baseline input total is negative");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> !div_rsp.done)
        else $error("divider finished right after a start");

endmodule

>>> design/aug_front.sv
// Input side: takes samples, splits them into sign and magnitude, queues them.
// Depends on aug_pkg.
module aug_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_ready,
    input  logic signed [aug_pkg::ANGLE_BITS-1:0] sample_angle,
    output logic                        q_valid,
    output aug_pkg::sample_item_t       q_item,
    input  logic                        q_pop
);
    import aug_pkg::*;

    sample_item_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         push;
    sample_item_t new_item;

    assign sample_ready = (count_reg != 2'd2);
    assign push         = sample_valid && sample_ready;
    assign q_valid      = (count_reg != 2'd0);
    assign q_item       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.neg = sample_angle[ANGLE_BITS-1];
        new_item.mag = new_item.neg ? (~sample_angle + 1'b1) : sample_angle;
        wr_ptr_next  = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next  = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next   = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/aug_div.sv
// Shared unsigned restoring divider, two quotient bits per cycle.
// Depends on aug_pkg.
module aug_div (
    input  logic              clk,
    input  logic              rst_n,
    input  aug_pkg::div_req_t req,
    output aug_pkg::div_rsp_t rsp
);
    import aug_pkg::*;

    logic [NUM_BITS-1:0]     num_reg, num_next;
    logic [NUM_BITS-1:0]     quo_reg, quo_next;
    logic [DEN_BITS-1:0]     den_reg, den_next;
    logic [DEN_BITS-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DEN_BITS:0]       t1, t2;
    logic [DEN_BITS-1:0]     r1;
    logic                    b1, b2;

    always_comb
    begin
        t1 = {rem_reg, num_reg[NUM_BITS-1]};
        b1 = (t1 >= {1'b0, den_reg});
        r1 = b1 ? DEN_BITS'(t1 - {1'b0, den_reg}) : t1[DEN_BITS-1:0];
        t2 = {r1, num_reg[NUM_BITS-2]};
        b2 = (t2 >= {1'b0, den_reg});

        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            num_next = {num_reg[NUM_BITS-3:0], 2'b00};
            quo_next = {quo_reg[NUM_BITS-3:0], b1, b2};
            rem_next = b2 ? DEN_BITS'(t2 - {1'b0, den_reg}) : t2[DEN_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            num_next  = req.num;
            den_next  = req.den;
            quo_next  = '0;
            rem_next  = '0;
            cnt_next  = DIV_CNT_BITS'(DIV_STEPS - 1);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> design/aug_back.sv
// Work side: wraps, unwraps, accumulates, gears and holds the result register.
// Depends on aug_pkg; drives the shared divider aug_div.
module aug_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [aug_pkg::PERIOD_BITS-1:0]      in_period,
    input  logic [aug_pkg::PERIOD_BITS-1:0]      out_period,
    input  logic [aug_pkg::RATIO_BITS-1:0]       ratio,
    input  logic                                 q_valid,
    input  aug_pkg::sample_item_t                q_item,
    output logic                                 q_pop,
    output aug_pkg::div_req_t                    div_req,
    input  aug_pkg::div_rsp_t                    div_rsp,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic                                 valid_res,
    output logic signed [aug_pkg::DELTA_BITS-1:0] input_delta,
    output logic [aug_pkg::PERIOD_BITS-1:0]      input_wrapped,
    output logic signed [aug_pkg::TOTAL_BITS-1:0] input_total,
    output logic signed [aug_pkg::TOTAL_BITS-1:0] output_total,
    output logic [aug_pkg::PERIOD_BITS-1:0]      output_wrapped,
    output logic signed [aug_pkg::TOTAL_BITS-1:0] output_delta
);
    import aug_pkg::*;

    back_state_t             state_reg, state_next;
    logic                    sneg_reg, sneg_next;
    logic                    qneg_reg, qneg_next;
    logic [PERIOD_BITS-1:0]  cur_reg, cur_next;
    logic [PERIOD_BITS-1:0]  prev_reg, prev_next;
    logic [PERIOD_BITS:0]    step_reg, step_next;
    logic [TOTAL_BITS-1:0]   itotal_reg, itotal_next;
    logic [TOTAL_BITS-1:0]   gtotal_reg, gtotal_next;
    logic [TOTAL_BITS-1:0]   gprev_reg, gprev_next;
    logic [PERIOD_BITS-1:0]  owrap_reg, owrap_next;
    logic                    base_reg, base_next;
    logic [PERIOD_BITS-1:0]  last_reg, last_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    res_valid_reg, res_valid_next;
    logic [DELTA_BITS-1:0]   res_idelta_reg, res_idelta_next;
    logic [PERIOD_BITS-1:0]  res_iwrap_reg, res_iwrap_next;
    logic [TOTAL_BITS-1:0]   res_itotal_reg, res_itotal_next;
    logic [TOTAL_BITS-1:0]   res_gtotal_reg, res_gtotal_next;
    logic [PERIOD_BITS-1:0]  res_owrap_reg, res_owrap_next;
    logic [TOTAL_BITS-1:0]   res_odelta_reg, res_odelta_next;

    logic [PERIOD_BITS-1:0]  pin, pout, mrem;
    logic [RATIO_BITS-1:0]   r_eff, r_mag;
    logic [PERIOD_BITS+1:0]  diff, twice, pin_ext;
    logic [TOTAL_BITS:0]     sum, dsum;
    logic [TOTAL_BITS-1:0]   t_mag, g_mag, lim, q_mag, g_new;
    logic                    over;
    logic [TOTAL_BITS-1:0]   odelta;

    always_comb
    begin
        pin     = (in_period == '0) ? FULL_TURN : in_period;
        pout    = (out_period == '0) ? FULL_TURN : out_period;
        mrem    = div_rsp.rem[PERIOD_BITS-1:0];
        r_eff   = (ratio == '0) ? ONE_FIX : ratio;
        r_mag   = r_eff[RATIO_BITS-1] ? (~r_eff + 1'b1) : r_eff;
        t_mag   = itotal_reg[TOTAL_BITS-1] ? (~itotal_reg + 1'b1) : itotal_reg;
        g_mag   = gtotal_reg[TOTAL_BITS-1] ? (~gtotal_reg + 1'b1) : gtotal_reg;
        pin_ext = {2'b00, pin};

        diff  = {2'b00, cur_reg} - {2'b00, prev_reg};
        twice = {diff[PERIOD_BITS:0], 1'b0};
        if ($signed(twice) > $signed(pin_ext))
        begin
            diff = diff - pin_ext;
        end
        else if ($signed(twice) < -$signed(pin_ext))
        begin
            diff = diff + pin_ext;
        end

        sum = {itotal_reg[TOTAL_BITS-1], itotal_reg}
            + {{(TOTAL_BITS-PERIOD_BITS){diff[PERIOD_BITS]}}, diff[PERIOD_BITS:0]};

        lim   = qneg_reg ? LIM_NEG : LIM_POS;
        over  = (div_rsp.quo[NUM_BITS-1:TOTAL_BITS] != '0)
             || (div_rsp.quo[TOTAL_BITS-1:0] > lim);
        q_mag = over ? lim : div_rsp.quo[TOTAL_BITS-1:0];
        g_new = qneg_reg ? (~q_mag + 1'b1) : q_mag;

        dsum = {gtotal_reg[TOTAL_BITS-1], gtotal_reg} - {gprev_reg[TOTAL_BITS-1], gprev_reg};
        if (dsum[TOTAL_BITS] != dsum[TOTAL_BITS-1])
        begin
            odelta = dsum[TOTAL_BITS] ? LIM_NEG : LIM_POS;
        end
        else
        begin
            odelta = dsum[TOTAL_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sneg_next       = sneg_reg;
        qneg_next       = qneg_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        step_next       = step_reg;
        itotal_next     = itotal_reg;
        gtotal_next     = gtotal_reg;
        gprev_next      = gprev_reg;
        owrap_next      = owrap_reg;
        base_next       = base_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        res_valid_next  = res_valid_reg;
        res_idelta_next = res_idelta_reg;
        res_iwrap_next  = res_iwrap_reg;
        res_itotal_next = res_itotal_reg;
        res_gtotal_next = res_gtotal_reg;
        res_owrap_next  = res_owrap_reg;
        res_odelta_next = res_odelta_reg;
        q_pop           = 1'b0;
        div_req.start   = 1'b0;
        div_req.num     = '0;
        div_req.den     = '0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    sneg_next     = q_item.neg;
                    div_req.start = 1'b1;
                    div_req.num   = NUM_BITS'(q_item.mag);
                    div_req.den   = DEN_BITS'(pin);
                    state_next    = BK_MOD_CUR;
                end
            end
            BK_MOD_CUR:
            begin
                if (div_rsp.done)
                begin
                    cur_next      = (sneg_reg && mrem != '0) ? (pin - mrem) : mrem;
                    div_req.start = 1'b1;
                    div_req.num   = NUM_BITS'(last_reg);
                    div_req.den   = DEN_BITS'(pin);
                    state_next    = BK_MOD_PREV;
                end
            end
            BK_MOD_PREV:
            begin
                if (div_rsp.done)
                begin
                    prev_next  = mrem;
                    state_next = BK_STEP;
                end
            end
            BK_STEP:
            begin
                if (base_reg)
                begin
                    step_next = diff[PERIOD_BITS:0];
                    if (sum[TOTAL_BITS] != sum[TOTAL_BITS-1])
                    begin
                        itotal_next = sum[TOTAL_BITS] ? LIM_NEG : LIM_POS;
                    end
                    else
                    begin
                        itotal_next = sum[TOTAL_BITS-1:0];
                    end
                end
                else
                begin
                    step_next   = '0;
                    itotal_next = TOTAL_BITS'(cur_reg);
                end
                state_next = BK_DIV_GO;
            end
            BK_DIV_GO:
            begin
                qneg_next     = itotal_reg[TOTAL_BITS-1] ^ r_eff[RATIO_BITS-1];
                div_req.start = 1'b1;
                div_req.num   = {t_mag, {FRACTION_BITS{1'b0}}};
                div_req.den   = DEN_BITS'(r_mag);
                state_next    = BK_DIV;
            end
            BK_DIV:
            begin
                if (div_rsp.done)
                begin
                    gprev_next  = base_reg ? gtotal_reg : g_new;
                    gtotal_next = g_new;
                    state_next  = BK_OUT_GO;
                end
            end
            BK_OUT_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = NUM_BITS'(g_mag);
                div_req.den   = DEN_BITS'(pout);
                state_next    = BK_MOD_OUT;
            end
            BK_MOD_OUT:
            begin
                if (div_rsp.done)
                begin
                    owrap_next = (gtotal_reg[TOTAL_BITS-1] && mrem != '0) ? (pout - mrem) : mrem;
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next  = 1'b1;
                    res_valid_next  = base_reg;
                    res_idelta_next = step_reg[DELTA_BITS-1:0];
                    res_iwrap_next  = cur_reg;
                    res_itotal_next = itotal_reg;
                    res_gtotal_next = gtotal_reg;
                    res_owrap_next  = owrap_reg;
                    res_odelta_next = base_reg ? odelta : '0;
                    base_next       = 1'b1;
                    last_next       = cur_reg;
                    state_next      = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sneg_reg       <= sneg_next;
        qneg_reg       <= qneg_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        step_reg       <= step_next;
        gprev_reg      <= gprev_next;
        owrap_reg      <= owrap_next;
        res_valid_reg  <= res_valid_next;
        res_idelta_reg <= res_idelta_next;
        res_iwrap_reg  <= res_iwrap_next;
        res_itotal_reg <= res_itotal_next;
        res_gtotal_reg <= res_gtotal_next;
        res_owrap_reg  <= res_owrap_next;
        res_odelta_reg <= res_odelta_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            base_reg      <= 1'b0;
            last_reg      <= '0;
            itotal_reg    <= '0;
            gtotal_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            last_reg      <= last_next;
            itotal_reg    <= itotal_next;
            gtotal_reg    <= gtotal_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign valid_res      = res_valid_reg;
    assign input_delta    = res_idelta_reg;
    assign input_wrapped  = res_iwrap_reg;
    assign input_total    = res_itotal_reg;
    assign output_total   = res_gtotal_reg;
    assign output_wrapped = res_owrap_reg;
    assign output_delta   = res_odelta_reg;

endmodule

>>> verif/testbench.sv
// Self-checking bench for angle_unwrap_gear_ratio_core: random and directed angle samples,
// several period and gear ratio settings, scoreboard with its own gearbox predictor.
// Depends on aug_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import aug_pkg::*;

    typedef struct packed {
        logic                  vld;
        logic [DELTA_BITS-1:0] idelta;
        logic [PERIOD_BITS-1:0] iwrap;
        logic [63:0]           itotal;
        logic [63:0]           ototal;
        logic [PERIOD_BITS-1:0] owrap;
        logic [63:0]           odelta;
    } gear_result_t;

    class gearbox_scoreboard;
        logic [30:0] in_period, out_period;
        logic [31:0] ratio;
        bit          have_base;
        logic [30:0] prev_wrap;
        longint      unwrap_sum, geared_sum;
        gear_result_t pending[$];
        int mismatches;

        function void clear();
            in_period = FULL_TURN; out_period = FULL_TURN; ratio = ONE_FIX;
            have_base = 0; prev_wrap = 0; unwrap_sum = 0; geared_sum = 0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [31:0] val);
            case (idx)
                REG_INPUT_PERIOD:  in_period = val[30:0];
                REG_OUTPUT_PERIOD: out_period = val[30:0];
                REG_GEAR_RATIO:    ratio = val;
                default: ;
            endcase
        endfunction

        function logic [63:0] wrap_into(longint v, logic [63:0] p);
            logic [63:0] mag, m;
            mag = (v < 0) ? 64'(-v) : 64'(v);
            m = mag % p;
            if (v < 0 && m != 0) m = p - m;
            return m;
        endfunction

        function longint sat_sum(longint a, longint b, bit sub);
            logic [64:0] r;
            longint bb;
            bb = b;
            r = sub ? ({a[63], a} - {bb[63], bb}) : ({a[63], a} + {bb[63], bb});
            if (r[64] != r[63]) return r[64] ? 64'h8000000000000000 : 64'h7fffffffffffffff;
            return r[63:0];
        endfunction

        function longint gear_divide(longint total);
            longint r;
            logic [63:0] d, n, q, rm, fr, lim, mag;
            bit neg;
            r = longint'(signed'(ratio));
            if (r == 0) r = 65536;
            d = (r < 0) ? 64'(-r) : 64'(r);
            n = (total < 0) ? 64'(-total) : 64'(total);
            neg = (total < 0) != (r < 0);
            lim = neg ? 64'h8000000000000000 : 64'h7fffffffffffffff;
            q = n / d;
            rm = n % d;
            fr = (rm << FRACTION_BITS) / d;
            if (q > (lim >> FRACTION_BITS)) mag = lim;
            else
            begin
                mag = (q << FRACTION_BITS) + fr;
                if (mag > lim) mag = lim;
            end
            return neg ? longint'(-mag) : longint'(mag);
        endfunction

        function void note_sample(logic [31:0] angle);
            logic [63:0] pin, pout, cur, prv;
            longint stp, prev_g, od;
            gear_result_t e;
            pin = (in_period == 0) ? 64'(FULL_TURN) : 64'(in_period);
            pout = (out_period == 0) ? 64'(FULL_TURN) : 64'(out_period);
            cur = wrap_into(longint'(signed'(angle)), pin);
            stp = 0; od = 0;
            if (!have_base)
            begin
                have_base = 1;
                unwrap_sum = cur;
                geared_sum = gear_divide(unwrap_sum);
                e.vld = 0;
            end
            else
            begin
                prv = 64'(prev_wrap) % pin;
                stp = longint'(cur) - longint'(prv);
                if (2 * stp > longint'(pin)) stp -= pin;
                else if (2 * stp < -longint'(pin)) stp += pin;
                unwrap_sum = sat_sum(unwrap_sum, stp, 0);
                prev_g = geared_sum;
                geared_sum = gear_divide(unwrap_sum);
                od = sat_sum(geared_sum, prev_g, 1);
                e.vld = 1;
            end
            prev_wrap = cur[30:0];
            e.idelta = stp[30:0];
            e.iwrap = cur[30:0];
            e.itotal = unwrap_sum;
            e.ototal = geared_sum;
            e.owrap = 31'(wrap_into(geared_sum, pout));
            e.odelta = od;
            pending.push_back(e);
        endfunction

        function void check_result(gear_result_t got);
            gear_result_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp %0b %h %h %h %h %h %h got %0b %h %h %h %h %h %h",
                        e.vld, e.idelta, e.iwrap, e.itotal, e.ototal, e.owrap, e.odelta,
                        got.vld, got.idelta, got.iwrap, got.itotal, got.ototal, got.owrap,
                        got.odelta);
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic cfg_write = 0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [RATIO_BITS-1:0] cfg_data = '0;
    logic sample_valid = 0, result_ready = 0;
    logic signed [ANGLE_BITS-1:0] sample_angle = '0;
    logic sample_ready, result_valid, valid_res;
    logic signed [DELTA_BITS-1:0] input_delta;
    logic [PERIOD_BITS-1:0] input_wrapped, output_wrapped;
    logic signed [TOTAL_BITS-1:0] input_total, output_total, output_delta;

    angle_unwrap_gear_ratio_core u_top (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    gearbox_scoreboard sb = new();
    int send_idle_pct = 0, stall_pct = 0;
    int cycles = 0, results_seen = 0, samples_sent = 0;
    localparam int CYCLE_LIMIT = 3000000;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && result_ready)
        begin
            gear_result_t g;
            g.vld = valid_res; g.idelta = input_delta; g.iwrap = input_wrapped;
            g.itotal = input_total; g.ototal = output_total; g.owrap = output_wrapped;
            g.odelta = output_delta;
            sb.check_result(g);
            results_seen++;
        end

    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_sample(logic [31:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 0;
            @(negedge clk);
        end
        sample_valid <= 1;
        sample_angle <= a;
        do @(posedge clk); while (!sample_ready);
        sb.note_sample(a);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        sample_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_write <= 0;
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_angle(logic [30:0] per);
        logic [63:0] p;
        p = (per == 0) ? 64'(FULL_TURN) : 64'(per);
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'(p)));
            2: return -32'($urandom_range(0, 32'(p)));
            default: return sb.prev_wrap + 32'($signed($urandom_range(0, 32'(p))) -
                                               $signed(32'(p >> 1)));
        endcase
    endfunction

    initial
    begin
        logic [31:0] dir_angles[$];
        logic [31:0] ratios[8];
        sb.clear();
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        dir_angles = '{0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1, 23592960,
                       32'd11796480, 32'd23592959, 32'd11796479, 32'd11796480, 0,
                       32'hff4c0000, 32'd5000000, 32'h7fff0000, 32'h80010000};
        foreach (dir_angles[i]) send_sample(dir_angles[i]);
        drain();
        write_reg(REG_INPUT_PERIOD, 0);
        write_reg(REG_OUTPUT_PERIOD, 0);
        write_reg(REG_GEAR_RATIO, 0);
        foreach (dir_angles[i]) if (i < 6) send_sample(dir_angles[i]);
        drain();
        write_reg(REG_INPUT_PERIOD, 32'h7fffffff);
        write_reg(REG_GEAR_RATIO, 32'h80000000);
        write_reg(REG_OUTPUT_PERIOD, 1);
        send_sample(32'h7fffffff); send_sample(32'h80000000); send_sample(32'h7fffffff);
        drain();
        write_reg(REG_INPUT_PERIOD, 4);
        write_reg(REG_GEAR_RATIO, 1);
        send_sample(2); send_sample(0); send_sample(32'hfffffffe);
        drain();
        ratios = '{32'h00010000, 32'hffff0000, 1, 32'h7fffffff, 32'h80000000,
                   32'h00008000, 32'hfffe8000, 0};
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 8; stall_pct = 8; end
            endcase
            write_reg(REG_INPUT_PERIOD, (ph % 3 == 0) ? 32'($urandom_range(1, 2000)) :
                                       (ph % 3 == 1) ? 32'(FULL_TURN) : $urandom);
            write_reg(REG_OUTPUT_PERIOD, (ph == 5) ? 0 : $urandom_range(1, 32'h7fffffff));
            write_reg(REG_GEAR_RATIO, (ph < 8) ? ratios[ph] : $urandom);
            for (int k = 0; k < 150; k++) send_sample(rand_angle(sb.in_period));
            drain();
        end
        send_idle_pct = 0; stall_pct = 0;
        drain();
        $display("covered %0d samples and %0d results over 12 setting phases",
                 samples_sent, results_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
